/* hdl/lhp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types, constants and the kernel function of the 3x3 high-pass filter
// ----------------------------------------------------------------------------
package lhp_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int ROW_W         = $clog2(MAX_HEIGHT);
	localparam int FW_W          = 11;
	localparam int FH_W          = 13;
	localparam int CFG_DATA_W    = 13;

	localparam logic [FW_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] HEIGHT_RST = 13'd480;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [7:0] pix_t;

	// one window column, [0] is the oldest row
	typedef pix_t [2:0] col_t;

	typedef struct packed {
		pix_t prev1;
		pix_t prev2;
	} line_pair_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctl_t;

	// 8 * centre minus the eight neighbors, clamped to 0..255
	function automatic pix_t lhp_laplace(col_t lc, col_t mc, col_t rc);
		logic [10:0] pos;
		logic [10:0] neg;
		logic [10:0] diff;
		pix_t        res;
		pos  = {mc[1], 3'b000};
		neg  = 11'(lc[0]) + 11'(lc[1]) + 11'(lc[2]) + 11'(mc[0])
		     + 11'(mc[2]) + 11'(rc[0]) + 11'(rc[1]) + 11'(rc[2]);
		diff = pos - neg;
		if (neg >= pos) begin
			res = 8'd0;
		end else if (diff > 11'd255) begin
			res = 8'd255;
		end else begin
			res = diff[7:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

/* hdl/lhp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhp stream interfaces
// Valid/ready channels for input items and filtered output pixels
// ----------------------------------------------------------------------------
interface lhp_in_if;
	import lhp_pkg::*;

	logic valid;
	logic ready;
	logic mode;
	pix_t pixel_in;

	modport source (output valid, output mode, output pixel_in, input ready);
	modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface lhp_out_if;
	import lhp_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel_out;
	logic frame_end;

	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface
`default_nettype wire

/* hdl/lhp_line_buf.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhp_line_buf
// Two-line pixel store, one column pair per entry, registered read
// ----------------------------------------------------------------------------
module lhp_line_buf #(
	parameter int DEPTH = lhp_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output lhp_pkg::line_pair_t           rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire lhp_pkg::line_pair_t      wr_data
);
	import lhp_pkg::*;

	line_pair_t mem [DEPTH];
	line_pair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

/* hdl/lhp_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhp_cell
// One column of the 3x3 window, shifted on from its right-hand neighbor
// ----------------------------------------------------------------------------
module lhp_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lhp_pkg::cell_ctl_t ctl,
	input  wire lhp_pkg::col_t      col_in,
	output lhp_pkg::col_t           col_out
);
	import lhp_pkg::*;

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.clear) begin
			col_q <= '0;
		end else if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule
`default_nettype wire

/* hdl/laplacian_high_pass_3x3.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// laplacian_high_pass_3x3
// Streaming 3x3 Laplacian high-pass filter over 8-bit raster-order pixels
// ----------------------------------------------------------------------------
// in_stream carries pixel items (mode 0) and flush items (mode 1); out_stream
// carries filtered pixels, one line plus one pixel behind their input, with
// frame_end marking the last pixel of the frame. Once a frame's pixels are all
// in, every item drains one remaining border output; flush items before that
// are dropped. The window is three column cells in a chain fed by a two-line
// store; the store's registered read sets three stages from transfer to result.
// Throughput: one item per cycle unless the receiver stalls; the store has a single port pair.
// cfg_wr_en writes frame_width (index 0) or frame_height (index 1) and restarts
// the frame; write only while the block is empty.
// Reset clears counters, the window and the pipeline control; sizes go to 640 x 480.
// The line store is not cleared; stale entries reach only results forced to border zeros.
// A stalled receiver holds the output register and the whole pipeline;
// in_stream.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module laplacian_high_pass_3x3 #(
	parameter int MAX_WIDTH = lhp_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire lhp_pkg::cfg_reg_t              cfg_index,
	input  wire logic [lhp_pkg::CFG_DATA_W-1:0] cfg_data,
	lhp_in_if.sink                              in_stream,
	lhp_out_if.source                           out_stream
);
	import lhp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [FW_W-1:0]  width_q;
	logic [FH_W-1:0]  height_q;
	logic [WW-1:0]    w_eff;
	logic [CW-1:0]    w_last;
	logic [FH_W-1:0]  h_eff;
	logic [ROW_W-1:0] h_last;

	logic [CW-1:0]    in_col_q;
	logic [ROW_W:0]   in_row_q;
	logic [CW-1:0]    out_col_q;
	logic [ROW_W-1:0] out_row_q;

	logic adv, acc, full, drain, pix, emit, interior, fe;

	logic          shift_s1, emit_s1, interior_s1, fe_s1;
	logic [CW-1:0] col_s1;
	pix_t          pixel_s1;
	logic          emit_s2, interior_s2, fe_s2;

	logic out_v_q;
	pix_t pixel_out_q;
	logic frame_end_q;

	line_pair_t rd_data;
	line_pair_t wr_data;
	cell_ctl_t  cell_ctl;
	col_t       chain [4];

	// effective frame size
	always_comb begin
		if (width_q < 11'd3) begin
			w_eff = WW'(3);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q < 13'd3) begin
			h_eff = 13'd3;
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = FH_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		w_last = CW'(w_eff - WW'(1));
		h_last = ROW_W'(h_eff - 13'd1);
	end

	// item decode at transfer
	assign adv      = !out_v_q || out_stream.ready;
	assign acc      = in_stream.valid && adv;
	assign full     = 32'(in_row_q) >= 32'(h_eff);
	assign drain    = acc && full;
	assign pix      = acc && !full && (in_stream.mode == MODE_PIXEL);
	assign emit     = drain || (pix && !((in_row_q == '0)
	                  || (in_row_q == (ROW_W+1)'(1) && in_col_q == '0)));
	assign interior = pix && (in_col_q >= CW'(2)) && (in_row_q >= (ROW_W+1)'(2));
	assign fe       = emit && (out_col_q == w_last) && (out_row_q == h_last);

	assign in_stream.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					width_q <= cfg_data[FW_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					height_q <= cfg_data[FH_W-1:0];
				end
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (acc) begin
			if (pix) begin
				if (in_col_q == w_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + (ROW_W+1)'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (emit) begin
				if (out_col_q == w_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
			if (fe) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_s1    <= 1'b0;
			emit_s1     <= 1'b0;
			interior_s1 <= 1'b0;
			fe_s1       <= 1'b0;
			emit_s2     <= 1'b0;
			interior_s2 <= 1'b0;
			fe_s2       <= 1'b0;
			out_v_q     <= 1'b0;
		end else if (adv) begin
			shift_s1    <= pix;
			emit_s1     <= emit;
			interior_s1 <= interior;
			fe_s1       <= fe;
			emit_s2     <= emit_s1;
			interior_s2 <= interior_s1;
			fe_s2       <= fe_s1;
			out_v_q     <= emit_s2;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1   <= in_col_q;
			pixel_s1 <= in_stream.pixel_in;
			if (emit_s2) begin
				pixel_out_q <= interior_s2 ? lhp_laplace(chain[0], chain[1], chain[2]) : 8'd0;
				frame_end_q <= fe_s2;
			end
		end
	end

	assign wr_data = '{prev1: pixel_s1, prev2: rd_data.prev1};

	lhp_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (pix),
		.rd_addr (in_col_q),
		.rd_data (rd_data),
		.wr_en   (adv && shift_s1),
		.wr_addr (col_s1),
		.wr_data (wr_data)
	);

	assign cell_ctl.clear = cfg_wr_en;
	assign cell_ctl.shift = adv && shift_s1;
	assign chain[3]       = {pixel_s1, rd_data.prev1, rd_data.prev2};

	for (genvar i = 0; i < 3; i++) begin : g_cell
		lhp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.col_in  (chain[i+1]),
			.col_out (chain[i])
		);
	end

	assign out_stream.valid     = out_v_q;
	assign out_stream.pixel_out = pixel_out_q;
	assign out_stream.frame_end = frame_end_q;

	// the last pixel of a frame is a border pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && frame_end_q |-> pixel_out_q == 8'd0)
		else $error("frame end on nonzero pixel");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q <= w_last)
		else $error("input column out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q <= h_last)
		else $error("output row out of range");

	// an interior item carries its pixel shift into stage s1
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && interior |=> shift_s1 && emit_s1)
		else $error("interior item lost its shift");

endmodule
`default_nettype wire
